// ===== rtl/core/ris_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ris_pkg: shared widths and register codes for the ray/sphere test
// Fixed-point format, datapath widths and configuration register indexes.
// ----------------------------------------------------------------------------
package ris_pkg;

  localparam int FRAC_BITS = 16;

  // field width (Q16.16 words)
  localparam int W   = 32;
  localparam int LW  = W + 1;        // origin - center
  localparam int AW  = 2 * W;        // a = d.d, unsigned
  localparam int HW  = 2 * W + 2;    // h = d.L, signed
  localparam int CW  = 2 * W + 3;    // c = L.L - r2, signed
  localparam int HMW = HW - 1;       // |h|
  localparam int CMW = CW - 1;       // |c|

  // limb split for the wide products
  localparam int HLW = (HMW + 1) / 2;
  localparam int HHW = HMW - HLW;
  localparam int ALW = AW / 2;
  localparam int AHW = AW - ALW;
  localparam int CLW = CMW / 2;
  localparam int CHW = CMW - CLW;

  localparam int PRW = 2 * HMW;      // h*h and a*|c| magnitudes
  localparam int RW  = PRW;          // square root radicand
  localparam int SW  = RW / 2;       // square root result
  localparam int DW  = RW + 2;       // signed discriminant
  localparam int QMW = SW + 1;       // |q| = |h| + s

  // divider
  localparam int DNW     = QMW;
  localparam int NW      = QMW + FRAC_BITS;
  localparam int TW      = W;                 // t magnitude, top bit marks saturation
  localparam int DIVQ    = TW - 1;
  localparam int DIV_LAT = DIVQ + 1;
  localparam int DIVCW   = DNW + DIVQ;
  localparam int SQ_LAT  = SW;

  localparam logic [1:0] REG_CENTER_X = 2'd0;
  localparam logic [1:0] REG_CENTER_Y = 2'd1;
  localparam logic [1:0] REG_CENTER_Z = 2'd2;
  localparam logic [1:0] REG_RADIUS_SQ = 2'd3;

  localparam logic [W-1:0] RSQ_RESET = W'(1) << FRAC_BITS;

endpackage

// ===== rtl/core/ris_sqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ris_sqrt: pipelined integer square root
// One result bit per stage, floor(sqrt(rad)), one operand per cycle while en is high.
// ----------------------------------------------------------------------------
module ris_sqrt import ris_pkg::*; (
  input  logic          clk,
  input  logic          en,
  input  logic [RW-1:0] rad,
  output logic [SW-1:0] root
);

  logic [SW+1:0] rem_q  [SW];
  logic [SW-1:0] root_q [SW];
  logic [RW-1:0] rest_q [SW-1];

  for (genvar j = 0; j < SW; j++) begin : g_stage
    logic [SW+1:0] rem_prev;
    logic [SW-1:0] root_prev;
    logic [RW-1:0] rest_prev;
    logic [SW+1:0] rem_sh;
    logic [SW+1:0] trial;
    logic          take;

    if (j == 0) begin : g_first
      assign rem_prev  = '0;
      assign root_prev = '0;
      assign rest_prev = rad;
    end else begin : g_next
      assign rem_prev  = rem_q[j-1];
      assign root_prev = root_q[j-1];
      assign rest_prev = rest_q[j-1];
    end

    // bring down the next two radicand bits
    assign rem_sh = {rem_prev[SW-1:0], rest_prev[RW-1 -: 2]};
    assign trial  = {root_prev, 2'b01};
    assign take   = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[j]  <= take ? rem_sh - trial : rem_sh;
        root_q[j] <= {root_prev[SW-2:0], take};
      end
    end

    if (j < SW - 1) begin : g_rest
      always_ff @(posedge clk) begin
        if (en) begin
          rest_q[j] <= rest_prev << 2;
        end
      end
    end
  end

  assign root = root_q[SW-1];

endmodule

// ===== rtl/core/ris_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ris_div: pipelined unsigned divider with saturation
// Restoring division, one quotient bit per stage; quotients of 2^31 or more
// come out as exactly 2^31.
// ----------------------------------------------------------------------------
module ris_div import ris_pkg::*; (
  input  logic           clk,
  input  logic           en,
  input  logic [NW-1:0]  num,
  input  logic [DNW-1:0] den,
  output logic [TW-1:0]  quo
);

  logic [NW-1:0]   rem_q  [DIV_LAT-1];
  logic [DNW-1:0]  den_q  [DIV_LAT-1];
  logic [DIVQ-1:0] bits_q [DIV_LAT];
  logic            big_q  [DIV_LAT];

  // first stage: flag quotients that do not fit below 2^31
  always_ff @(posedge clk) begin
    if (en) begin
      rem_q[0]  <= num;
      den_q[0]  <= den;
      bits_q[0] <= '0;
      big_q[0]  <= DIVCW'(num) >= (DIVCW'(den) << DIVQ);
    end
  end

  for (genvar j = 1; j < DIV_LAT; j++) begin : g_stage
    localparam int K = DIVQ - j;
    logic [DIVCW-1:0] dsh;
    logic             take;

    assign dsh  = DIVCW'(den_q[j-1]) << K;
    assign take = DIVCW'(rem_q[j-1]) >= dsh;

    always_ff @(posedge clk) begin
      if (en) begin
        bits_q[j] <= bits_q[j-1] | (DIVQ'(take) << K);
        big_q[j]  <= big_q[j-1];
      end
    end

    if (j < DIV_LAT - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[j] <= take ? NW'(DIVCW'(rem_q[j-1]) - dsh) : rem_q[j-1];
          den_q[j] <= den_q[j-1];
        end
      end
    end
  end

  assign quo = big_q[DIV_LAT-1] ? (TW'(1) << DIVQ) : TW'(bits_q[DIV_LAT-1]);

endmodule

// ===== rtl/core/ray_sphere_intersect_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_sphere_intersect_unit: ray versus sphere hit test, Q16.16 fixed point
// Forms the quadratic from origin - center, takes the exact discriminant,
// the stable roots q/a and c/q, and reports the nearest accepted t.
//
//   channel | signals                           | transfer
//   --------+-----------------------------------+---------------------------
//   in      | in_valid, in_stall, ray fields    | in_valid & !in_stall
//   out     | out_valid, out_stall, hit, t_hit  | out_valid & !out_stall
//   cfg     | cfg_valid, cfg_ready, index, data | cfg_valid & cfg_ready
//
// One ray per cycle unless the output stalls. Stages: 7 of products and sums,
// 65 square root stages, 1 stage for q, 32 divider stages, 1 output register.
// Reset clears the valid bits and loads the sphere registers; no clearing pass.
// A stalled result freezes the whole pipeline; nothing enters while it holds.
// ----------------------------------------------------------------------------
module ray_sphere_intersect_unit import ris_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [W-1:0] origin_x,
  input  logic signed [W-1:0] origin_y,
  input  logic signed [W-1:0] origin_z,
  input  logic signed [W-1:0] dir_x,
  input  logic signed [W-1:0] dir_y,
  input  logic signed [W-1:0] dir_z,
  input  logic signed [W-1:0] t_start,
  input  logic signed [W-1:0] t_end,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                hit,
  output logic [W-2:0]        t_hit,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [W-1:0]        cfg_data
);

  typedef struct packed {
    logic [HMW-1:0]     hm;
    logic               hpos;
    logic [CMW-1:0]     cm;
    logic               cneg;
    logic               czero;
    logic [AW-1:0]      a;
    logic               azero;
    logic               dneg;
    logic               dzero;
    logic signed [W-1:0] ts;
    logic signed [W-1:0] te;
  } side_t;

  // sphere registers
  logic signed [W-1:0] center_x, center_y, center_z;
  logic [W-1:0]        radius_squared;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x       <= '0;
      center_y       <= '0;
      center_z       <= '0;
      radius_squared <= RSQ_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CENTER_X:  center_x       <= signed'(cfg_data);
        REG_CENTER_Y:  center_y       <= signed'(cfg_data);
        REG_CENTER_Z:  center_z       <= signed'(cfg_data);
        REG_RADIUS_SQ: radius_squared <= cfg_data;
        default: ;
      endcase
    end
  end

  // whole pipeline advances unless the output holds a stalled beat
  logic en;
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // valid bits
  logic              v1, v2, v3, v4, v5, v6, v7, v8;
  logic [SQ_LAT-1:0]  sq_v;
  logic [DIV_LAT-1:0] dv_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      v4   <= 1'b0;
      v5   <= 1'b0;
      v6   <= 1'b0;
      v7   <= 1'b0;
      v8   <= 1'b0;
      sq_v <= '0;
      dv_v <= '0;
    end else if (en) begin
      v1   <= in_valid;
      v2   <= v1;
      v3   <= v2;
      v4   <= v3;
      v5   <= v4;
      v6   <= v5;
      v7   <= v6;
      sq_v <= {sq_v[SQ_LAT-2:0], v7};
      v8   <= sq_v[SQ_LAT-1];
      dv_v <= {dv_v[DIV_LAT-2:0], v8};
    end
  end

  // stage 1: L = origin - center
  logic signed [LW-1:0] lx, ly, lz;
  logic signed [W-1:0]  dx, dy, dz;
  logic signed [W-1:0]  ts1, te1, ts2, te2, ts3, te3;

  always_ff @(posedge clk) begin
    if (en) begin
      lx  <= LW'(origin_x) - LW'(center_x);
      ly  <= LW'(origin_y) - LW'(center_y);
      lz  <= LW'(origin_z) - LW'(center_z);
      dx  <= dir_x;
      dy  <= dir_y;
      dz  <= dir_z;
      ts1 <= t_start;
      te1 <= t_end;
    end
  end

  // stage 2: element products
  logic signed [AW-1:0]     ddx, ddy, ddz;
  logic signed [2*W:0]      dlx, dly, dlz;
  logic signed [2*LW-1:0]   llx, lly, llz;

  always_ff @(posedge clk) begin
    if (en) begin
      ddx <= dx * dx;
      ddy <= dy * dy;
      ddz <= dz * dz;
      dlx <= dx * lx;
      dly <= dy * ly;
      dlz <= dz * lz;
      llx <= lx * lx;
      lly <= ly * ly;
      llz <= lz * lz;
      ts2 <= ts1;
      te2 <= te1;
    end
  end

  // stage 3: a, h, c
  logic [AW-1:0]        a3;
  logic signed [HW-1:0] h3;
  logic signed [CW-1:0] c3;
  logic signed [CW-1:0] rsq_sh;

  assign rsq_sh = signed'(CW'(radius_squared) << FRAC_BITS);

  always_ff @(posedge clk) begin
    if (en) begin
      a3  <= $unsigned(ddx) + $unsigned(ddy) + $unsigned(ddz);
      h3  <= HW'(dlx) + HW'(dly) + HW'(dlz);
      c3  <= CW'(llx) + CW'(lly) + CW'(llz) - rsq_sh;
      ts3 <= ts2;
      te3 <= te2;
    end
  end

  // stage 4: magnitudes and signs
  side_t side4, side5, side6, side7;

  always_ff @(posedge clk) begin
    if (en) begin
      side4.hm    <= h3[HW-1] ? HMW'(-h3) : HMW'(h3);
      side4.hpos  <= !h3[HW-1] && (h3 != '0);
      side4.cm    <= c3[CW-1] ? CMW'(-c3) : CMW'(c3);
      side4.cneg  <= c3[CW-1];
      side4.czero <= c3 == '0;
      side4.a     <= a3;
      side4.azero <= a3 == '0;
      side4.dneg  <= 1'b0;
      side4.dzero <= 1'b0;
      side4.ts    <= ts3;
      side4.te    <= te3;
    end
  end

  // stage 5: limb products of h*h and a*|c|
  logic [2*HLW-1:0]     hll5;
  logic [HLW+HHW-1:0]   hlh5;
  logic [2*HHW-1:0]     hhh5;
  logic [ALW+CLW-1:0]   alcl5;
  logic [ALW+CHW-1:0]   alch5;
  logic [AHW+CLW-1:0]   ahcl5;
  logic [AHW+CHW-1:0]   ahch5;

  always_ff @(posedge clk) begin
    if (en) begin
      hll5  <= side4.hm[HLW-1:0] * side4.hm[HLW-1:0];
      hlh5  <= side4.hm[HLW-1:0] * side4.hm[HMW-1:HLW];
      hhh5  <= side4.hm[HMW-1:HLW] * side4.hm[HMW-1:HLW];
      alcl5 <= side4.a[ALW-1:0] * side4.cm[CLW-1:0];
      alch5 <= side4.a[ALW-1:0] * side4.cm[CMW-1:CLW];
      ahcl5 <= side4.a[AW-1:ALW] * side4.cm[CLW-1:0];
      ahch5 <= side4.a[AW-1:ALW] * side4.cm[CMW-1:CLW];
      side5 <= side4;
    end
  end

  // stage 6: combine limbs
  logic [PRW-1:0] h2_6, ach6, acl6;

  always_ff @(posedge clk) begin
    if (en) begin
      h2_6  <= (PRW'(hhh5) << (2 * HLW)) + (PRW'(hlh5) << (HLW + 1)) + PRW'(hll5);
      ach6  <= (PRW'(ahch5) << (ALW + CLW)) + (PRW'(alch5) << CLW);
      acl6  <= (PRW'(ahcl5) << ALW) + PRW'(alcl5);
      side6 <= side5;
    end
  end

  // stage 7: discriminant h*h - a*c
  logic signed [DW-1:0] disc7;

  always_ff @(posedge clk) begin
    if (en) begin
      if (side6.cneg) begin
        disc7 <= signed'(DW'(h2_6) + DW'(ach6) + DW'(acl6));
      end else begin
        disc7 <= signed'(DW'(h2_6) - DW'(ach6) - DW'(acl6));
      end
      side7 <= side6;
    end
  end

  // square root, sideband travels alongside
  side_t         sq_in;
  logic [RW-1:0] rad7;
  logic [SW-1:0] root;
  side_t         sq_side [SQ_LAT];

  always_comb begin
    sq_in       = side7;
    sq_in.dneg  = disc7[DW-1];
    sq_in.dzero = disc7 == '0;
  end

  assign rad7 = disc7[DW-1] ? '0 : disc7[RW-1:0];

  ris_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .rad  (rad7),
    .root (root)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      sq_side[0] <= sq_in;
      for (int k = 1; k < SQ_LAT; k++) begin
        sq_side[k] <= sq_side[k-1];
      end
    end
  end

  // stage 8: |q| = |h| + s, q is negative exactly when h > 0
  logic [QMW-1:0] qm8;
  side_t          side8;

  always_ff @(posedge clk) begin
    if (en) begin
      qm8   <= QMW'(sq_side[SQ_LAT-1].hm) + QMW'(root);
      side8 <= sq_side[SQ_LAT-1];
    end
  end

  // dividers: q/a (or -h/a for a double root) and c/q
  logic [NW-1:0]  num_a, num_b;
  logic [DNW-1:0] den_a, den_b;
  logic [TW-1:0]  quo_a, quo_b;
  side_t          dv_side [DIV_LAT];

  assign num_a = NW'(side8.dzero ? QMW'(side8.hm) : qm8) << FRAC_BITS;
  assign den_a = DNW'(side8.a);
  assign num_b = NW'(side8.cm) << FRAC_BITS;
  assign den_b = DNW'(qm8);

  ris_div u_div_a (
    .clk (clk),
    .en  (en),
    .num (num_a),
    .den (den_a),
    .quo (quo_a)
  );

  ris_div u_div_b (
    .clk (clk),
    .en  (en),
    .num (num_b),
    .den (den_b),
    .quo (quo_b)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      dv_side[0] <= side8;
      for (int k = 1; k < DIV_LAT; k++) begin
        dv_side[k] <= dv_side[k-1];
      end
    end
  end

  // root selection and interval test
  side_t               fin;
  logic                fv;
  logic                x0neg, x1neg;
  logic [TW-1:0]       tsel, t_n;
  logic signed [W:0]   tsel_s, ts_s, te_s;
  logic                hit_nz, hit_n;
  logic [W-2:0]        t_out;

  assign fin = dv_side[DIV_LAT-1];
  assign fv  = dv_v[DIV_LAT-1];

  always_comb begin
    x0neg = fin.hpos;
    x1neg = !fin.czero && (fin.cneg ^ fin.hpos);
    if (x0neg) begin
      tsel = quo_b;
    end else if (x1neg) begin
      tsel = quo_a;
    end else begin
      tsel = (quo_a < quo_b) ? quo_a : quo_b;
    end
    tsel_s = signed'({1'b0, tsel});
    ts_s   = (W + 1)'(fin.ts);
    te_s   = (W + 1)'(fin.te);
    hit_nz = !(x0neg && x1neg) && (tsel_s >= ts_s) && (tsel_s < te_s);

    // double root skips the interval test
    if (fin.azero || fin.dneg) begin
      hit_n = 1'b0;
    end else if (fin.dzero) begin
      hit_n = !fin.hpos;
    end else begin
      hit_n = hit_nz;
    end

    t_n = fin.dzero ? quo_a : tsel;
    if (!hit_n) begin
      t_out = '0;
    end else if (t_n[TW-1]) begin
      t_out = '1;
    end else begin
      t_out = t_n[TW-2:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= fv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit   <= hit_n;
      t_hit <= t_out;
    end
  end

  // checks
  a_miss_no_root: assert property (@(posedge clk) disable iff (rst)
    en && fv && (fin.dneg || fin.azero) |=> out_valid && !hit)
    else $error("ray without real root reported as hit");

  a_miss_zero_t: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> t_hit == '0)
    else $error("miss carries nonzero t");

  a_freeze: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(qm8) && $stable(v8) && $stable(sq_v) && $stable(dv_v))
    else $error("pipeline moved while output stalled");

endmodule
